### rtl/core/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg: shared types and constants
// Payload structs, controller command and status, and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cel_pkg;

  localparam int unsigned MAX_CLASSES = 1024;
  localparam int unsigned MAX_OBS     = 65536;
  localparam int unsigned NC_W        = 11;
  localparam int unsigned OBS_W       = 17;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned DVD_W       = 41;
  localparam int unsigned DIV_STEPS   = 41;
  localparam int unsigned LOG_STEPS   = 24;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;

  typedef struct packed {
    logic [15:0] prob;
    logic [9:0]  true_class;
    logic        end_of_batch;
  } in_t;

  typedef struct packed {
    logic signed [31:0] grad;
    logic               loss_valid;
    logic [23:0]        mean_loss;
    logic               bad_label;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic grad_ld;
    logic log_step;
    logic mul;
    logic rnd;
    logic acc;
    logic mean_ld;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pzero;
    logic eob;
    logic div_done;
    logic log_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/cross_entropy_loss_and_gradient_unit.sv
// ----------------------------------------------------------------------------
// cross_entropy_loss_and_gradient_unit: cross-entropy loss and gradient
// One gradient beat per probability beat; mean loss on the batch end beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  in_t (prob, true_class, end_of_batch)
//  out_     output     out_valid/out_stall out_t (grad, loss_valid, mean_loss, bad_label)
//  cfg_     input      cfg_we             num_classes
//
//  A label beat with nonzero probability passes through the 41-step shared divider
//  and the 24-step log squaring loop; a beat off the label row skips both.
//  A batch end beat adds the mean division in the same divider.
//  Synchronous active-low reset clears the batch state and num_classes to 10.
//  A stalled result sits in the output register while the next beat is taken.
`default_nettype none

module cross_entropy_loss_and_gradient_unit import cel_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_t             in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_t                 out_data,
  input  wire logic            cfg_we,
  input  wire logic [NC_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  cel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cel_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/core/cel_ctrl.sv
// ----------------------------------------------------------------------------
// cel_ctrl: sequencing controller
// Steps one item through divide, log, multiply, accumulate and mean.
// ----------------------------------------------------------------------------
`default_nettype none

module cel_ctrl import cel_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RDIV = 4'd2;
  localparam logic [3:0] S_LOG  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_RND  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_MST  = 4'd7;
  localparam logic [3:0] S_MDIV = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.hit && !sts.pzero) state_nxt = S_RDIV;
        else if (sts.hit) state_nxt = S_ACC;
        else if (sts.eob) state_nxt = S_MST;
        else state_nxt = S_DONE;
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.grad_ld = 1'b1;
          state_nxt = S_LOG;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_LOG: begin
        if (sts.log_done) state_nxt = S_MUL;
        else cmd.log_step = 1'b1;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_nxt = sts.eob ? S_MST : S_DONE;
      end
      S_MST: begin
        cmd.mean_ld = 1'b1;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        if (sts.div_done) state_nxt = S_DONE;
        else cmd.div_step = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cel_dp.sv
// ----------------------------------------------------------------------------
// cel_dp: datapath
// Batch state, shared restoring divider, log2 squaring unit, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cel_dp import cel_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [NC_W-1:0] cfg_wdata,
  input  wire in_t             in_data,
  input  wire cmd_t            cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_t                 out_data
);

  logic [NC_W-1:0]  nc_cfg_r;
  logic [9:0]       row_r;
  logic [SUM_W-1:0] sum_r;
  logic [OBS_W-1:0] obs_r;

  logic [15:0] prob_r;
  logic        hit_r, eob_r, bad_r;
  logic [31:0] grad_r;

  logic [DVD_W-1:0] dvd_r;
  logic [OBS_W-1:0] dvs_r;
  logic [OBS_W:0]   rem_r;
  logic [5:0]       dcnt_r;

  logic [31:0] x_r;
  logic [23:0] frac_r;
  logic [4:0]  lcnt_r;
  logic [3:0]  k_r;
  logic [60:0] prod_r;
  logic [23:0] term_r;

  logic        ov_r;
  out_t        out_r;

  logic [NC_W-1:0] nc;
  logic            bad, hit, col_end;
  logic [3:0]      k;
  logic [OBS_W:0]  rem_sh;
  logic            ge;
  logic [63:0]     sq;
  logic [32:0]     sqt;
  logic [28:0]     lval;
  logic [40:0]     sum_add;
  logic [DVD_W-1:0] mean_dvd;
  logic [23:0]     mean_sat;
  logic [31:0]     mag;

  always_comb begin
    nc = nc_cfg_r;
    if (nc_cfg_r < NC_W'(2)) nc = NC_W'(2);
    if (nc_cfg_r > NC_W'(MAX_CLASSES)) nc = NC_W'(MAX_CLASSES);
    bad = {1'b0, in_data.true_class} >= nc;
    hit = !bad && (row_r == in_data.true_class);
    col_end = in_data.end_of_batch || (({1'b0, row_r} + NC_W'(1)) >= nc);
    k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (in_data.prob[i]) k = 4'(i);
    end
  end

  assign rem_sh = {rem_r[OBS_W-1:0], dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign sq     = x_r * x_r;
  assign sqt    = sq[63:31];
  assign lval   = {(5'd16 - {1'b0, k_r}), 24'd0} - {5'd0, frac_r};
  assign sum_add = {1'b0, sum_r} + {17'd0, term_r};
  assign mean_dvd = {1'b0, sum_r} + {25'd0, obs_r[OBS_W-1:1]};
  assign mean_sat = (dvd_r > DVD_W'(24'hFFFFFF)) ? 24'hFFFFFF : dvd_r[23:0];
  assign mag = (dvd_r > DVD_W'(33'h80000000)) ? 32'h80000000 : dvd_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_cfg_r <= NC_W'(10);
      row_r    <= '0;
      sum_r    <= '0;
      obs_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) nc_cfg_r <= cfg_wdata;
      if (cmd.load) begin
        if (col_end) begin
          row_r <= '0;
          if (obs_r < OBS_W'(MAX_OBS)) obs_r <= obs_r + OBS_W'(1);
        end else begin
          row_r <= row_r + 10'd1;
        end
      end
      if (cmd.acc) sum_r <= sum_add[40] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      if (cmd.mean_ld) begin
        sum_r <= '0;
        obs_r <= '0;
      end
      if (cmd.out_ld) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prob_r <= in_data.prob;
      hit_r  <= hit;
      eob_r  <= in_data.end_of_batch;
      bad_r  <= bad;
      grad_r <= (hit && in_data.prob == 16'd0) ? 32'h80000000 : 32'd0;
      term_r <= 24'hFFFFFF;
      dvd_r  <= {8'd0, 1'b1, 16'd0, 1'b0, in_data.prob[15:1]};
      dvs_r  <= {1'b0, in_data.prob};
      rem_r  <= '0;
      dcnt_r <= '0;
      k_r    <= k;
      x_r    <= {16'd0, in_data.prob} << (5'd31 - {1'b0, k});
      frac_r <= '0;
      lcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dvd_r  <= {dvd_r[DVD_W-2:0], ge};
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.grad_ld) grad_r <= 32'd0 - mag;
    if (cmd.log_step) begin
      x_r    <= sqt[32] ? sqt[32:1] : sqt[31:0];
      frac_r <= {frac_r[22:0], sqt[32]};
      lcnt_r <= lcnt_r + 5'd1;
    end
    if (cmd.mul) prod_r <= lval * LN2_Q32;
    if (cmd.rnd) term_r <= {3'd0, 21'((prod_r + 61'(64'h8000000000)) >> 40)};
    if (cmd.mean_ld) begin
      dvd_r  <= mean_dvd;
      dvs_r  <= obs_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.out_ld) begin
      out_r.grad       <= grad_r;
      out_r.loss_valid <= eob_r;
      out_r.mean_loss  <= eob_r ? mean_sat : 24'd0;
      out_r.bad_label  <= bad_r;
    end
  end

  always_comb begin
    sts.hit      = hit_r;
    sts.pzero    = (prob_r == 16'd0);
    sts.eob      = eob_r;
    sts.div_done = (dcnt_r == 6'(DIV_STEPS));
    sts.log_done = (lcnt_r == 5'(LOG_STEPS));
    sts.out_free = !ov_r || !out_stall;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/core/cel_checker.sv
// ----------------------------------------------------------------------------
// cel_checker: port checks
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cel_checker import cel_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.loss_valid |-> out_data.mean_loss == 24'd0)
    else $error("mean loss set without loss_valid");

  a_bad_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_label |-> out_data.grad == 32'sd0)
    else $error("gradient on bad label");

  a_grad_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.grad[31] || out_data.grad == 32'sd0)
    else $error("positive gradient");

endmodule

bind cross_entropy_loss_and_gradient_unit cel_checker u_cel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
